@@ rtl/core/assert_macros.svh @@
// Assertion helpers used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// a holds in the same cycle as b
`define ASSERT_IMPLY(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> (b)) \
		else $error("implication check failed");

// a in this cycle gives b in the next
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |=> (b)) \
		else $error("next-cycle check failed");

`endif

@@ rtl/core/crpi_pkg.sv @@
package crpi_pkg;

	localparam int PIXEL_BITS          = 64;
	localparam int FRACTION_FIELD_BITS = 16;
	localparam int NUM_LANES           = 4;
	localparam int NUM_STAGES          = 7;

	localparam int DEFAULT_CHANNEL_BITS  = 16;
	localparam int DEFAULT_FRACTION_BITS = 16;

	// per-stage load enables from the pipeline control to each channel
	typedef struct packed {
		logic [NUM_STAGES-1:0] en;
	} crpi_stage_ctrl_t;

endpackage

@@ rtl/core/crpi_pixel_in_if.sv @@
interface crpi_pixel_in_if;
	import crpi_pkg::*;

	logic                           valid;
	logic                           ready;
	logic [PIXEL_BITS-1:0]          pixel_before;
	logic [PIXEL_BITS-1:0]          pixel_left;
	logic [PIXEL_BITS-1:0]          pixel_right;
	logic [PIXEL_BITS-1:0]          pixel_after;
	logic [FRACTION_FIELD_BITS-1:0] position_fraction;

	modport source (
		output valid, pixel_before, pixel_left, pixel_right, pixel_after,
			position_fraction,
		input  ready
	);

	modport sink (
		input  valid, pixel_before, pixel_left, pixel_right, pixel_after,
			position_fraction,
		output ready
	);

endinterface

@@ rtl/core/crpi_pixel_out_if.sv @@
interface crpi_pixel_out_if;
	import crpi_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [PIXEL_BITS-1:0] pixel_out;

	modport source (
		output valid, pixel_out,
		input  ready
	);

	modport sink (
		input  valid, pixel_out,
		output ready
	);

endinterface

@@ rtl/core/crpi_pipe_ctrl.sv @@
`include "assert_macros.svh"

module crpi_pipe_ctrl (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	output logic                      out_valid,
	input  logic                      out_ready,
	output crpi_pkg::crpi_stage_ctrl_t ctrl
);
	import crpi_pkg::*;

	logic [NUM_STAGES-1:0] valid_q;
	logic [NUM_STAGES:0]   ready;
	logic [NUM_STAGES-1:0] up_valid;

	// a stage takes a beat when it is empty or its successor moves on
	always_comb begin
		ready[NUM_STAGES] = out_ready;
		for (int k = NUM_STAGES - 1; k >= 0; k--) begin
			ready[k] = !valid_q[k] || ready[k+1];
		end
	end

	assign up_valid = {valid_q[NUM_STAGES-2:0], in_valid};
	assign ctrl.en  = ready[NUM_STAGES-1:0] & up_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			valid_q <= (valid_q & ~ready[NUM_STAGES-1:0]) | (up_valid & ready[NUM_STAGES-1:0]);
		end
	end

	assign in_ready  = ready[0];
	assign out_valid = valid_q[NUM_STAGES-1];

	`ASSERT_NEXT(a_accept_fills_first, clk, arst_n, in_valid && in_ready, valid_q[0])
	`ASSERT_IMPLY(a_blocked_only_full, clk, arst_n, !in_ready, &valid_q)
	`ASSERT_NEXT(a_last_refills, clk, arst_n, valid_q[NUM_STAGES-2] && out_ready, valid_q[NUM_STAGES-1])

endmodule

@@ rtl/core/crpi_channel.sv @@
module crpi_channel #(
	parameter int CHANNEL_BITS  = crpi_pkg::DEFAULT_CHANNEL_BITS,
	parameter int FRACTION_BITS = crpi_pkg::DEFAULT_FRACTION_BITS
) (
	input  logic                       clk,
	input  crpi_pkg::crpi_stage_ctrl_t ctrl,
	input  logic [CHANNEL_BITS-1:0]    p0,
	input  logic [CHANNEL_BITS-1:0]    p1,
	input  logic [CHANNEL_BITS-1:0]    p2,
	input  logic [CHANNEL_BITS-1:0]    p3,
	input  logic [FRACTION_BITS-1:0]   t,
	output logic [CHANNEL_BITS-1:0]    y
);
	import crpi_pkg::*;

	localparam int CW = CHANNEL_BITS + 4;          // doubled coefficients
	localparam int RW = CHANNEL_BITS + 5;          // Horner partials
	localparam int TW = FRACTION_BITS + 1;         // t as a signed operand
	localparam int PW = RW + TW;                   // products and sums
	localparam logic signed [PW-1:0] HALF =
		{{(PW-FRACTION_BITS){1'b0}}, 1'b1, {(FRACTION_BITS-1){1'b0}}};
	localparam logic signed [PW-1:0] ONE =
		{{(PW-FRACTION_BITS-1){1'b0}}, 1'b1, {FRACTION_BITS{1'b0}}};

	logic signed [CW-1:0] e0, e1, e2, e3, e12;
	logic signed [CW-1:0] a_c, b_c, c_c, d_c;

	logic signed [CW-1:0]       a_s1, b_s1, c_s1, d_s1;
	logic [FRACTION_BITS-1:0]   t_s1;
	logic signed [PW-1:0]       pa_s2;
	logic signed [CW-1:0]       b_s2, c_s2, d_s2;
	logic [FRACTION_BITS-1:0]   t_s2;
	logic signed [RW-1:0]       r1_s3;
	logic signed [CW-1:0]       c_s3, d_s3;
	logic [FRACTION_BITS-1:0]   t_s3;
	logic signed [PW-1:0]       pr1_s4;
	logic signed [CW-1:0]       c_s4, d_s4;
	logic [FRACTION_BITS-1:0]   t_s4;
	logic signed [RW-1:0]       r2_s5;
	logic signed [CW-1:0]       d_s5;
	logic [FRACTION_BITS-1:0]   t_s5;
	logic signed [PW-1:0]       pr2_s6;
	logic signed [CW-1:0]       d_s6;
	logic [CHANNEL_BITS-1:0]    y_s7;

	logic signed [TW-1:0] t_s1x, t_s3x, t_s5x;
	logic signed [PW-1:0] h1, h2, h3;
	logic signed [RW-1:0] yr;
	logic [CHANNEL_BITS-1:0] y_sat;

	// A = -p0+3p1-3p2+p3, B = 2p0-5p1+4p2-p3, C = p2-p0, D = 2p1
	assign e0  = $signed(CW'(p0));
	assign e1  = $signed(CW'(p1));
	assign e2  = $signed(CW'(p2));
	assign e3  = $signed(CW'(p3));
	assign e12 = e1 - e2;
	assign a_c = e3 - e0 + e12 + (e12 <<< 1);
	assign b_c = (e0 <<< 1) - (e1 <<< 2) - e1 + (e2 <<< 2) - e3;
	assign c_c = e2 - e0;
	assign d_c = e1 <<< 1;

	assign t_s1x = $signed({1'b0, t_s1});
	assign t_s3x = $signed({1'b0, t_s3});
	assign t_s5x = $signed({1'b0, t_s5});

	// round half up is an arithmetic shift after adding half
	assign h1 = pa_s2 + (PW'(b_s2) <<< FRACTION_BITS) + HALF;
	assign h2 = pr1_s4 + (PW'(c_s4) <<< FRACTION_BITS) + HALF;
	assign h3 = pr2_s6 + (PW'(d_s6) <<< FRACTION_BITS) + ONE;
	assign yr = RW'(h3 >>> (FRACTION_BITS + 1));

	always_comb begin
		priority if (yr[RW-1]) begin
			y_sat = '0;
		end else if (yr[RW-2:CHANNEL_BITS] != '0) begin
			y_sat = '1;
		end else begin
			y_sat = yr[CHANNEL_BITS-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.en[0]) begin
			a_s1 <= a_c;
			b_s1 <= b_c;
			c_s1 <= c_c;
			d_s1 <= d_c;
			t_s1 <= t;
		end
		if (ctrl.en[1]) begin
			pa_s2 <= PW'(a_s1) * PW'(t_s1x);
			b_s2  <= b_s1;
			c_s2  <= c_s1;
			d_s2  <= d_s1;
			t_s2  <= t_s1;
		end
		if (ctrl.en[2]) begin
			r1_s3 <= RW'(h1 >>> FRACTION_BITS);
			c_s3  <= c_s2;
			d_s3  <= d_s2;
			t_s3  <= t_s2;
		end
		if (ctrl.en[3]) begin
			pr1_s4 <= PW'(r1_s3) * PW'(t_s3x);
			c_s4   <= c_s3;
			d_s4   <= d_s3;
			t_s4   <= t_s3;
		end
		if (ctrl.en[4]) begin
			r2_s5 <= RW'(h2 >>> FRACTION_BITS);
			d_s5  <= d_s4;
			t_s5  <= t_s4;
		end
		if (ctrl.en[5]) begin
			pr2_s6 <= PW'(r2_s5) * PW'(t_s5x);
			d_s6   <= d_s5;
		end
		if (ctrl.en[6]) begin
			y_s7 <= y_sat;
		end
	end

	assign y = y_s7;

endmodule

@@ rtl/core/catmull_rom_pixel_interpolator.sv @@
// Catmull-Rom cubic interpolation of one RGBA pixel per beat.
//
// samples (sink): four neighbouring pixels p0..p3 and the fraction t in
//   Q0.FRACTION_BITS (low bits of position_fraction). Each pixel packs four
//   unsigned CHANNEL_BITS channels, R lowest; higher bits are ignored.
// result (source): the interpolated pixel, each channel rounded and
//   clamped to 0..2^CHANNEL_BITS-1, unused high bits zero.
//
// A new beat is taken every cycle unless the pipeline is full and
// stalled; throughput is one pixel per clock, set by the seven-stage
// datapath (three multiply stages, three add/round stages and the
// coefficient stage) with one multiplier per channel per multiply stage.
// Reset clears only the stage valid bits; the pipeline comes up empty.
// When the receiver holds result.ready low the last stage keeps its pixel;
// earlier stages keep filling empty slots, and samples.ready drops only
// once all seven stages hold a pixel. Nothing is dropped or duplicated.
module catmull_rom_pixel_interpolator #(
	parameter int CHANNEL_BITS  = crpi_pkg::DEFAULT_CHANNEL_BITS,
	parameter int FRACTION_BITS = crpi_pkg::DEFAULT_FRACTION_BITS
) (
	input  logic              clk,
	input  logic              arst_n,
	crpi_pixel_in_if.sink     samples,
	crpi_pixel_out_if.source  result
);
	import crpi_pkg::*;

	crpi_stage_ctrl_t ctrl;
	logic [FRACTION_BITS+FRACTION_FIELD_BITS-1:0] t_wide;
	logic [FRACTION_BITS-1:0] t;
	logic [CHANNEL_BITS-1:0]  lane_y [NUM_LANES];

	assign t_wide = {{FRACTION_BITS{1'b0}}, samples.position_fraction};
	assign t      = t_wide[FRACTION_BITS-1:0];

	crpi_pipe_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (samples.valid),
		.in_ready  (samples.ready),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.ctrl      (ctrl)
	);

	for (genvar k = 0; k < NUM_LANES; k++) begin : g_lane
		crpi_channel #(
			.CHANNEL_BITS  (CHANNEL_BITS),
			.FRACTION_BITS (FRACTION_BITS)
		) u_channel (
			.clk  (clk),
			.ctrl (ctrl),
			.p0   (samples.pixel_before[k*CHANNEL_BITS +: CHANNEL_BITS]),
			.p1   (samples.pixel_left[k*CHANNEL_BITS +: CHANNEL_BITS]),
			.p2   (samples.pixel_right[k*CHANNEL_BITS +: CHANNEL_BITS]),
			.p3   (samples.pixel_after[k*CHANNEL_BITS +: CHANNEL_BITS]),
			.t    (t),
			.y    (lane_y[k])
		);
	end

	always_comb begin
		result.pixel_out = '0;
		for (int k = 0; k < NUM_LANES; k++) begin
			result.pixel_out[k*CHANNEL_BITS +: CHANNEL_BITS] = lane_y[k];
		end
	end

endmodule
